[rtl/imucal_pkg.sv]
// Shared types and constants for the IMU leaky-integrator calibrator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package imucal_pkg;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_ZERO   = 2'd1,
		OP_START  = 2'd2,
		OP_STOP   = 2'd3
	} op_t;

	localparam int NUM_AXES = 9;
	localparam int NUM_GAIN_AXES = 5;
	localparam int FIRST_SPAN_AXIS = 5;
	localparam int ACCEL_Z_AXIS = 5;
	localparam int MAG_Z_AXIS = 8;
	localparam int FIRST_RANGE_AXIS = 3;
	localparam int GYRO_AXES = 3;
	localparam int ACCEL_END_AXIS = 6;

	localparam logic REG_GYRO_GAIN = 1'b0;
	localparam logic REG_ACCEL_GAIN = 1'b1;
	localparam logic [31:0] GAIN_RESET = 32'd65536;

	localparam int QBITS = 17;
	localparam int MILLI = 1000;
	localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [15:0] SAT_MIN = 16'sh8000;

endpackage

[rtl/imu_iir_min_max_calibrator.sv]
// Top level of the IMU calibrator: axis record memory, sequencer and output register.
// Depends on imucal_pkg and instantiates imucal_div.
`timescale 1ns / 1ps
// Usage: an item enters on the in_valid/in_ready channel and carries an opcode
// plus nine raw axes and an optional pressure reading. A sample produces one
// result transfer on the out_valid/out_ready channel; the three commands
// produce none. Gains are written over the APB port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// The per-axis state sits in a nine-entry record memory with a registered
// read; the sequencer visits the axes one at a time, read then write back.
// In a sample each gain axis passes through the shared multiplier and each
// span axis with a non-zero span through the shared bit-serial divider,
// between an entry step and an output step. Stop completes in the accept
// cycle. Reset returns the gains to unity, clears filters, centers, ranges
// and the barometer, and turns range mode off; the memory reads as zero
// until each entry is written. A finished result waits in the output
// register while the receiver stalls, and the next item is accepted
// meanwhile, but a sample cannot finish until that result has been taken.

module imu_iir_min_max_calibrator import imucal_pkg::*; #(
	parameter int GYRO_DEPTH = 4,
	parameter int ACCEL_DEPTH = 4,
	parameter int MAG_DEPTH = 4,
	parameter int BARO_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	input  logic [16:0]        baro_value,
	input  logic               baro_valid,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] cal_gyro_x,
	output logic signed [15:0] cal_gyro_y,
	output logic signed [15:0] cal_gyro_z,
	output logic signed [15:0] cal_accel_x,
	output logic signed [15:0] cal_accel_y,
	output logic signed [15:0] cal_accel_z,
	output logic signed [15:0] cal_mag_x,
	output logic signed [15:0] cal_mag_y,
	output logic signed [15:0] cal_mag_z,
	output logic [16:0]        filtered_baro,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int DMAX_GA = (GYRO_DEPTH > ACCEL_DEPTH) ? GYRO_DEPTH : ACCEL_DEPTH;
	localparam int DMAX = (DMAX_GA > MAG_DEPTH) ? DMAX_GA : MAG_DEPTH;
	localparam int FW = 16 + DMAX;
	localparam int BW = 17 + BARO_DEPTH;
	localparam int PW = FW + 34;
	localparam int NUMW = FW + 13;

	typedef struct packed {
		logic signed [FW-1:0] filt;
		logic signed [15:0]   last;
		logic signed [FW-1:0] cen;
		logic signed [FW-1:0] mn;
		logic signed [FW-1:0] mx;
	} axis_rec_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD   = 7'b0000010,
		ST_UPD  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_GRES = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t st_q;
	op_t op_q;
	logic [3:0] idx_q;
	logic range_q;
	logic [31:0] gyro_gain_q;
	logic [31:0] accel_gain_q;
	logic [BW-1:0] baro_q;
	logic [16:0] last_baro_q;
	logic signed [15:0] smp_q [NUM_AXES];
	logic signed [15:0] res_q [NUM_AXES];

	axis_rec_t mem_q [NUM_AXES];
	axis_rec_t rdata_q;
	logic [NUM_AXES-1:0] vld_q;
	logic rvld_q;

	logic signed [FW:0] diff_q;
	logic signed [PW-1:0] prod_q;

	logic out_valid_q;
	logic signed [15:0] out_q [NUM_AXES];
	logic [16:0] fbaro_q;

	logic in_acc;
	logic cfg_wr;
	logic mem_we;
	axis_rec_t rd;
	axis_rec_t wr;
	logic signed [15:0] x;
	logic [3:0] d;
	logic signed [FW-1:0] sx;
	logic signed [FW-1:0] sl;
	logic signed [FW-1:0] nf;
	logic signed [FW:0] span_w;
	logic signed [FW:0] a_w;
	logic signed [FW+2:0] t_w;
	logic signed [NUMW-1:0] num_w;
	logic signed [FW:0] diff_w;
	logic div_start;
	logic div_done;
	logic signed [15:0] div_quo;
	logic signed [PW-1:0] p_adj;
	logic signed [PW-1:0] p_q16;
	logic signed [15:0] gres;
	logic load_out;
	logic last_axis;

	function automatic logic [3:0] depth_of(input logic [3:0] a);
		if (a < 4'(GYRO_AXES)) begin
			return 4'(GYRO_DEPTH);
		end else if (a < 4'(ACCEL_END_AXIS)) begin
			return 4'(ACCEL_DEPTH);
		end
		return 4'(MAG_DEPTH);
	endfunction

	assign in_ready = (st_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ACCEL_GAIN) ? accel_gain_q : gyro_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_gain_q <= GAIN_RESET;
			accel_gain_q <= GAIN_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_GYRO_GAIN) begin
				gyro_gain_q <= pwdata;
			end else begin
				accel_gain_q <= pwdata;
			end
		end
	end

	always_comb begin
		rd = rvld_q ? rdata_q : '0;
		x = smp_q[idx_q];
		d = depth_of(idx_q);
		sx = {{DMAX{x[15]}}, x} <<< d;
		sl = {{DMAX{rd.last[15]}}, rd.last} <<< d;
		nf = rd.filt - (rd.filt >>> d) + FW'(x);
		span_w = {rd.mx[FW-1], rd.mx} - {rd.mn[FW-1], rd.mn};
		a_w = {sx[FW-1], sx} - {rd.mn[FW-1], rd.mn};
		t_w = {a_w[FW], a_w, 1'b0} - {{2{span_w[FW]}}, span_w};
		num_w = NUMW'(t_w) * NUMW'(MILLI);
		diff_w = {sx[FW-1], sx} - {rd.cen[FW-1], rd.cen};
		wr = rd;
		unique case (op_q)
			OP_ZERO: begin
				wr.cen = rd.filt;
			end
			OP_START: begin
				wr.filt = sl;
				if (idx_q == 4'(ACCEL_Z_AXIS)) begin
					wr.mn = sl;
					wr.mx = sl;
				end else if (idx_q == 4'(MAG_Z_AXIS)) begin
					wr.mn = '0;
					wr.mx = '0;
				end
			end
			OP_SAMPLE: begin
				wr.filt = nf;
				wr.last = x;
				if (range_q && idx_q >= 4'(FIRST_RANGE_AXIS)) begin
					if (nf > rd.mx) begin
						wr.mx = nf;
					end
					if (nf < rd.mn) begin
						wr.mn = nf;
					end
				end
			end
			OP_STOP: begin
				wr = rd;
			end
		endcase
	end

	assign mem_we = (st_q == ST_UPD);
	assign last_axis = (op_q == OP_ZERO) ? (idx_q == 4'(NUM_GAIN_AXES - 1))
		: (idx_q == 4'(NUM_AXES - 1));
	assign div_start = (st_q == ST_UPD) && (op_q == OP_SAMPLE)
		&& (idx_q >= 4'(FIRST_SPAN_AXIS)) && (span_w != '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[idx_q] <= wr;
		end
		if (st_q == ST_RD) begin
			rdata_q <= mem_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (st_q == ST_RD) begin
				rvld_q <= vld_q[idx_q];
			end
		end
	end

	imucal_div #(
		.FW(FW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_w),
		.span  (span_w[FW-1:0]),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		p_adj = prod_q + (prod_q[PW-1] ? PW'(65535) : PW'(0));
		p_q16 = p_adj >>> 16;
		if (p_q16 > PW'(32767)) begin
			gres = SAT_MAX;
		end else if (p_q16 < PW'(-32768)) begin
			gres = SAT_MIN;
		end else begin
			gres = p_q16[15:0];
		end
	end

	assign load_out = (st_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q[0] <= gyro_x;
			smp_q[1] <= gyro_y;
			smp_q[2] <= gyro_z;
			smp_q[3] <= accel_x;
			smp_q[4] <= accel_y;
			smp_q[5] <= accel_z;
			smp_q[6] <= mag_x;
			smp_q[7] <= mag_y;
			smp_q[8] <= mag_z;
		end
		if (st_q == ST_UPD && idx_q < 4'(NUM_GAIN_AXES)) begin
			diff_q <= diff_w;
		end
		if (st_q == ST_MUL) begin
			prod_q <= diff_q * $signed({1'b0,
				(idx_q < 4'(GYRO_AXES)) ? gyro_gain_q : accel_gain_q});
		end
		if (st_q == ST_GRES) begin
			res_q[idx_q] <= gres;
		end
		if (div_done && st_q == ST_DIV) begin
			res_q[idx_q] <= div_quo;
		end
		if (st_q == ST_UPD && op_q == OP_SAMPLE && idx_q >= 4'(FIRST_SPAN_AXIS)
			&& span_w == '0) begin
			res_q[idx_q] <= '0;
		end
		if (load_out) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				out_q[i] <= res_q[i];
			end
			fbaro_q <= baro_q[BW-1:BARO_DEPTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			op_q <= OP_SAMPLE;
			idx_q <= '0;
			range_q <= 1'b0;
			baro_q <= '0;
			last_baro_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q <= op_t'(opcode);
						idx_q <= '0;
						unique case (op_t'(opcode))
							OP_STOP: begin
								range_q <= 1'b0;
							end
							OP_START: begin
								range_q <= 1'b1;
								baro_q <= BW'(last_baro_q) << BARO_DEPTH;
								st_q <= ST_RD;
							end
							OP_SAMPLE: begin
								if (baro_valid) begin
									last_baro_q <= baro_value;
									baro_q <= baro_q - (baro_q >> BARO_DEPTH)
										+ BW'(baro_value);
								end
								st_q <= ST_RD;
							end
							OP_ZERO: begin
								st_q <= ST_RD;
							end
						endcase
					end
				end
				ST_RD: begin
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (op_q != OP_SAMPLE) begin
						if (last_axis) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 4'd1;
							st_q <= ST_RD;
						end
					end else if (idx_q < 4'(NUM_GAIN_AXES)) begin
						st_q <= ST_MUL;
					end else if (div_start) begin
						st_q <= ST_DIV;
					end else if (last_axis) begin
						st_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + 4'd1;
						st_q <= ST_RD;
					end
				end
				ST_MUL: begin
					st_q <= ST_GRES;
				end
				ST_GRES: begin
					idx_q <= idx_q + 4'd1;
					st_q <= ST_RD;
				end
				ST_DIV: begin
					if (div_done) begin
						if (last_axis) begin
							st_q <= ST_OUT;
						end else begin
							idx_q <= idx_q + 4'd1;
							st_q <= ST_RD;
						end
					end
				end
				ST_OUT: begin
					if (load_out) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign cal_gyro_x = out_q[0];
	assign cal_gyro_y = out_q[1];
	assign cal_gyro_z = out_q[2];
	assign cal_accel_x = out_q[3];
	assign cal_accel_y = out_q[4];
	assign cal_accel_z = out_q[5];
	assign cal_mag_x = out_q[6];
	assign cal_mag_y = out_q[7];
	assign cal_mag_z = out_q[8];
	assign filtered_baro = fbaro_q;

endmodule

[rtl/imucal_div.sv]
// Iterative signed-by-positive divider for the span mapping, one quotient bit per cycle.
// Depends on imucal_pkg for the quotient width and the saturation limits.
`timescale 1ns / 1ps

module imucal_div import imucal_pkg::*; #(
	parameter int FW = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [FW+12:0]   num,
	input  logic        [FW-1:0]    span,
	output logic                    done,
	output logic signed [15:0]      quo
);

	localparam int NUMW = FW + 13;
	localparam int DW = FW + 17;

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dv_q;
	logic [QBITS-1:0] q_q;
	logic neg_q;
	logic sat_q;
	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [NUMW-1:0] mag_w;

	assign mag_w = num[NUMW-1] ? NUMW'(-num) : num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(QBITS + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUMW-1];
			rem_q <= DW'(mag_w);
			dv_q <= DW'(span) << (QBITS - 1);
			q_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 5'(QBITS + 1)) begin
				sat_q <= (rem_q >= {dv_q[DW-2:0], 1'b0});
			end else begin
				if (rem_q >= dv_q) begin
					rem_q <= rem_q - dv_q;
					q_q <= {q_q[QBITS-2:0], 1'b1};
				end else begin
					q_q <= {q_q[QBITS-2:0], 1'b0};
				end
				dv_q <= dv_q >> 1;
			end
		end
	end

	always_comb begin
		if (sat_q) begin
			quo = neg_q ? SAT_MIN : SAT_MAX;
		end else if (neg_q) begin
			quo = (q_q > QBITS'(32768)) ? SAT_MIN : -$signed(q_q[15:0]);
		end else begin
			quo = (q_q > QBITS'(32767)) ? SAT_MAX : $signed(q_q[15:0]);
		end
	end

	assign done = done_q;

endmodule

[rtl/imucal_chk.sv]
// Port-level checker for the IMU calibrator and the bind that attaches it.
// Depends on imucal_pkg for the opcode names.
`timescale 1ns / 1ps

module imucal_chk import imucal_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         opcode,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] cal_gyro_x,
	input logic signed [15:0] cal_mag_z,
	input logic [16:0]        filtered_baro
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cal_gyro_x)
			&& $stable(cal_mag_z) && $stable(filtered_baro))
		else $error("result changed while stalled");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_SAMPLE |=> !in_ready)
		else $error("sample transfer did not occupy the block");

	a_stop_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_STOP |=> in_ready)
		else $error("stop command did not complete at once");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a sample in progress");

endmodule

bind imu_iir_min_max_calibrator imucal_chk u_imucal_chk (.*);
